>>> sv/ycbcr_range_matrix_convert_top_macros.svh
// ---------------------------------------------------------------------------
// YCbCr range/matrix converter: assertion macros
// Concurrent assertion helpers; they compile to nothing for synthesis.
// ---------------------------------------------------------------------------
`ifndef YCBCR_RANGE_MATRIX_CONVERT_TOP_MACROS_SVH
`define YCBCR_RANGE_MATRIX_CONVERT_TOP_MACROS_SVH

`ifndef SYNTHESIS

// The consequent must hold in the cycle after the antecedent.
`define YRMC_ASSERT_NEXT(name, clock, resetn, ante, cons, msg) \
    name: assert property (@(posedge clock) disable iff (!resetn) (ante) |=> (cons)) \
        else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define YRMC_ASSERT_SAME(name, clock, resetn, ante, cons, msg) \
    name: assert property (@(posedge clock) disable iff (!resetn) (ante) |-> (cons)) \
        else $error(msg);

`else

`define YRMC_ASSERT_NEXT(name, clock, resetn, ante, cons, msg)

`define YRMC_ASSERT_SAME(name, clock, resetn, ante, cons, msg)

`endif

`endif

>>> sv/yrmc_pkg.sv
// ---------------------------------------------------------------------------
// YCbCr range/matrix converter: shared package
// Fixed-point coefficients, pipeline depth and shared types.
// ---------------------------------------------------------------------------
package yrmc_pkg;

    // Fraction bits of the internal code values.
    localparam int Q_BITS = 16;

    // Default fraction bits of the output codes.
    localparam int OUT_FRAC_BITS_DEF = 8;

    // Number of register stages, including the output register.
    localparam int NUM_STAGES = 9;

    typedef logic [NUM_STAGES-1:0] stage_en_t;
    typedef logic [1:0]            model_t;

    // Bit positions inside the output model code.
    localparam int MODEL_LIM_BIT = 0;
    localparam int MODEL_709_BIT = 1;

    // Q2.16 coefficients, each round(c * 65536).
    localparam logic [16:0] K_R_CR   = 17'd91881;
    localparam logic [16:0] K_G_CB   = 17'd22553;
    localparam logic [16:0] K_G_CR   = 17'd46802;
    localparam logic [16:0] K_B_CB   = 17'd116130;
    localparam logic [16:0] K_WR     = 17'd13933;
    localparam logic [16:0] K_WG     = 17'd46871;
    localparam logic [16:0] K_WB     = 17'd4732;
    localparam logic [16:0] K_INV_CB = 17'd35318;
    localparam logic [16:0] K_INV_CR = 17'd41615;
    localparam logic [16:0] K_LIM_Y  = 17'd56284;
    localparam logic [16:0] K_LIM_C  = 17'd57569;

endpackage

>>> sv/yrmc_ifs.sv
// ---------------------------------------------------------------------------
// YCbCr range/matrix converter: stream interfaces
// Valid/ready channels for the input pixel and the converted pixel.
// ---------------------------------------------------------------------------

// Input pixel channel: 8-bit full-range Y, Cb and Cr codes.
interface yrmc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] luma_in;
    logic [7:0] blue_diff_in;
    logic [7:0] red_diff_in;

    modport source (output valid, output luma_in, output blue_diff_in,
                    output red_diff_in, input ready);
    modport sink   (input valid, input luma_in, input blue_diff_in,
                    input red_diff_in, output ready);
endinterface

// Result channel: 16-bit unsigned fixed-point Y, Cb and Cr codes.
interface yrmc_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] luma_out;
    logic [15:0] blue_diff_out;
    logic [15:0] red_diff_out;

    modport source (output valid, output luma_out, output blue_diff_out,
                    output red_diff_out, input ready);
    modport sink   (input valid, input luma_out, input blue_diff_out,
                    input red_diff_out, output ready);
endinterface

>>> sv/ycbcr_range_matrix_convert_top.sv
// Throughput: one pixel per cycle unless a result stall has backed up to the input;
// each of the 9 pipeline registers moves on its own. A stalled result holds its
// register and every full stage right behind it; bubbles further up are filled meanwhile.
// Reset clears every stage valid bit and sets the output model register to full-range BT.601.
// ---------------------------------------------------------------------------
// YCbCr range/matrix converter: top level
// Converts full-range BT.601 YCbCr pixels to the selected output model.
// ---------------------------------------------------------------------------
`include "ycbcr_range_matrix_convert_top_macros.svh"

module ycbcr_range_matrix_convert_top #(
    parameter int OUT_FRAC_BITS = yrmc_pkg::OUT_FRAC_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  yrmc_pkg::model_t cfg_wr_data,
    yrmc_in_if.sink          pixel,
    yrmc_out_if.source       result
);

    localparam int LAST = yrmc_pkg::NUM_STAGES - 1;

    yrmc_pkg::model_t    model_reg;
    yrmc_pkg::stage_en_t valid_reg;
    yrmc_pkg::stage_en_t valid_next;
    yrmc_pkg::stage_en_t stage_en;

    // Output model register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            model_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            model_reg <= cfg_wr_data;
        end
    end

    // A stage loads when it is empty or its content moves on.
    always_comb
    begin
        stage_en[LAST] = !valid_reg[LAST] || result.ready;
        for (int k = LAST - 1; k >= 0; k--)
        begin
            stage_en[k] = !valid_reg[k] || stage_en[k + 1];
        end
    end

    // Valid bits travel with the data.
    always_comb
    begin
        valid_next[0] = stage_en[0] ? pixel.valid : valid_reg[0];
        for (int k = 1; k <= LAST; k++)
        begin
            valid_next[k] = stage_en[k] ? valid_reg[k - 1] : valid_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign pixel.ready  = stage_en[0];
    assign result.valid = valid_reg[LAST];

    // Arithmetic pipeline.
    yrmc_datapath #(
        .OUT_FRAC_BITS (OUT_FRAC_BITS)
    ) u_datapath (
        .clk         (clk),
        .stage_en    (stage_en),
        .model       (model_reg),
        .luma        (pixel.luma_in),
        .blue_diff   (pixel.blue_diff_in),
        .red_diff    (pixel.red_diff_in),
        .luma_q      (result.luma_out),
        .blue_diff_q (result.blue_diff_out),
        .red_diff_q  (result.red_diff_out)
    );

    // Pipeline checks.
    `YRMC_ASSERT_NEXT(a_accept_fills_first, clk, rst_n, pixel.valid && pixel.ready, valid_reg[0], "accepted transaction did not enter the first stage")
    `YRMC_ASSERT_SAME(a_full_stall_blocks, clk, rst_n, (&valid_reg) && !result.ready, !pixel.ready, "input ready while every stage is full and stalled")
    `YRMC_ASSERT_NEXT(a_stage_advance, clk, rst_n, valid_reg[3] && stage_en[4], valid_reg[4], "item lost between the luma sum and chroma stages")

endmodule

>>> sv/yrmc_datapath.sv
// ---------------------------------------------------------------------------
// YCbCr range/matrix converter: arithmetic pipeline
// Nine register stages: RGB matrix, clamp, luma weights, luma sum, chroma
// scale, model select, range scale, offset add and output rounding.
// ---------------------------------------------------------------------------
module yrmc_datapath #(
    parameter int OUT_FRAC_BITS = yrmc_pkg::OUT_FRAC_BITS_DEF
) (
    input  logic                clk,
    input  yrmc_pkg::stage_en_t stage_en,
    input  yrmc_pkg::model_t    model,
    input  logic [7:0]          luma,
    input  logic [7:0]          blue_diff,
    input  logic [7:0]          red_diff,
    output logic [15:0]         luma_q,
    output logic [15:0]         blue_diff_q,
    output logic [15:0]         red_diff_q
);

    localparam int          SHIFT    = yrmc_pkg::Q_BITS - OUT_FRAC_BITS;
    localparam logic [28:0] OUT_RND  = 29'((64'd1 << SHIFT) >> 1);
    localparam logic [26:0] CODE_TOP = 27'd16711680;
    localparam logic [24:0] LIM_OFS  = 25'd1048576;
    localparam logic [27:0] MID      = 28'd8388608;

    // Clamp a signed Q.16 value to the code range 0..255.
    function automatic logic [23:0] clamp_code(input logic signed [26:0] x);
        logic [23:0] res;
        if (x < 0)
        begin
            res = '0;
        end
        else if ($unsigned(x) > CODE_TOP)
        begin
            res = CODE_TOP[23:0];
        end
        else
        begin
            res = x[23:0];
        end
        return res;
    endfunction

    // Drop negatives, round to the output precision and saturate.
    function automatic logic [15:0] to_output(input logic signed [27:0] v);
        logic [28:0] mag;
        logic [28:0] rnd;
        mag = v[27] ? '0 : {1'b0, v};
        rnd = (mag + OUT_RND) >> SHIFT;
        return (rnd > 29'd65535) ? 16'hFFFF : rnd[15:0];
    endfunction

    // Stage 0: chroma offsets removed and RGB formed from the matrix.
    logic signed [7:0]  db;
    logic signed [7:0]  dr;
    logic signed [26:0] db_w;
    logic signed [26:0] dr_w;
    logic signed [26:0] y_ext;
    logic signed [26:0] p_rcr;
    logic signed [26:0] p_gcb;
    logic signed [26:0] p_gcr;
    logic signed [26:0] p_bcb;
    logic signed [26:0] s0_r_next;
    logic signed [26:0] s0_g_next;
    logic signed [26:0] s0_b_next;
    logic signed [26:0] s0_r_reg;
    logic signed [26:0] s0_g_reg;
    logic signed [26:0] s0_b_reg;
    logic [7:0]         s0_y_reg;
    logic signed [7:0]  s0_db_reg;
    logic signed [7:0]  s0_dr_reg;
    yrmc_pkg::model_t   s0_model_reg;

    assign db    = $signed({~blue_diff[7], blue_diff[6:0]});
    assign dr    = $signed({~red_diff[7], red_diff[6:0]});
    assign db_w  = $signed({{19{db[7]}}, db});
    assign dr_w  = $signed({{19{dr[7]}}, dr});
    assign y_ext = $signed({3'b000, luma, 16'h0000});
    assign p_rcr = $signed({10'd0, yrmc_pkg::K_R_CR}) * dr_w;
    assign p_gcb = $signed({10'd0, yrmc_pkg::K_G_CB}) * db_w;
    assign p_gcr = $signed({10'd0, yrmc_pkg::K_G_CR}) * dr_w;
    assign p_bcb = $signed({10'd0, yrmc_pkg::K_B_CB}) * db_w;
    assign s0_r_next = y_ext + p_rcr;
    assign s0_g_next = y_ext - p_gcb - p_gcr;
    assign s0_b_next = y_ext + p_bcb;

    always_ff @(posedge clk)
    begin
        if (stage_en[0])
        begin
            s0_r_reg     <= s0_r_next;
            s0_g_reg     <= s0_g_next;
            s0_b_reg     <= s0_b_next;
            s0_y_reg     <= luma;
            s0_db_reg    <= db;
            s0_dr_reg    <= dr;
            s0_model_reg <= model;
        end
    end

    // Stage 1: clamp each RGB channel.
    logic [23:0]       s1_r_reg;
    logic [23:0]       s1_g_reg;
    logic [23:0]       s1_b_reg;
    logic [7:0]        s1_y_reg;
    logic signed [7:0] s1_db_reg;
    logic signed [7:0] s1_dr_reg;
    yrmc_pkg::model_t  s1_model_reg;

    always_ff @(posedge clk)
    begin
        if (stage_en[1])
        begin
            s1_r_reg     <= clamp_code(s0_r_reg);
            s1_g_reg     <= clamp_code(s0_g_reg);
            s1_b_reg     <= clamp_code(s0_b_reg);
            s1_y_reg     <= s0_y_reg;
            s1_db_reg    <= s0_db_reg;
            s1_dr_reg    <= s0_dr_reg;
            s1_model_reg <= s0_model_reg;
        end
    end

    // Stage 2: BT.709 luma weight products.
    logic [39:0]       s2_wr_next;
    logic [39:0]       s2_wg_next;
    logic [39:0]       s2_wb_next;
    logic [39:0]       s2_wr_reg;
    logic [39:0]       s2_wg_reg;
    logic [39:0]       s2_wb_reg;
    logic [23:0]       s2_r_reg;
    logic [23:0]       s2_b_reg;
    logic [7:0]        s2_y_reg;
    logic signed [7:0] s2_db_reg;
    logic signed [7:0] s2_dr_reg;
    yrmc_pkg::model_t  s2_model_reg;

    assign s2_wr_next = {23'd0, yrmc_pkg::K_WR} * {16'd0, s1_r_reg};
    assign s2_wg_next = {23'd0, yrmc_pkg::K_WG} * {16'd0, s1_g_reg};
    assign s2_wb_next = {23'd0, yrmc_pkg::K_WB} * {16'd0, s1_b_reg};

    always_ff @(posedge clk)
    begin
        if (stage_en[2])
        begin
            s2_wr_reg    <= s2_wr_next;
            s2_wg_reg    <= s2_wg_next;
            s2_wb_reg    <= s2_wb_next;
            s2_r_reg     <= s1_r_reg;
            s2_b_reg     <= s1_b_reg;
            s2_y_reg     <= s1_y_reg;
            s2_db_reg    <= s1_db_reg;
            s2_dr_reg    <= s1_dr_reg;
            s2_model_reg <= s1_model_reg;
        end
    end

    // Stage 3: luma sum, rounded back to Q.16.
    logic [39:0]       yy_sum;
    logic [23:0]       s3_yy_next;
    logic [23:0]       s3_yy_reg;
    logic [23:0]       s3_r_reg;
    logic [23:0]       s3_b_reg;
    logic [7:0]        s3_y_reg;
    logic signed [7:0] s3_db_reg;
    logic signed [7:0] s3_dr_reg;
    yrmc_pkg::model_t  s3_model_reg;

    assign yy_sum     = s2_wr_reg + s2_wg_reg + s2_wb_reg + 40'd32768;
    assign s3_yy_next = yy_sum[39:16];

    always_ff @(posedge clk)
    begin
        if (stage_en[3])
        begin
            s3_yy_reg    <= s3_yy_next;
            s3_r_reg     <= s2_r_reg;
            s3_b_reg     <= s2_b_reg;
            s3_y_reg     <= s2_y_reg;
            s3_db_reg    <= s2_db_reg;
            s3_dr_reg    <= s2_dr_reg;
            s3_model_reg <= s2_model_reg;
        end
    end

    // Stage 4: color differences scaled into Cb and Cr.
    logic signed [24:0] dby;
    logic signed [24:0] dry;
    logic signed [41:0] s4_pcb_next;
    logic signed [41:0] s4_pcr_next;
    logic signed [41:0] s4_pcb_reg;
    logic signed [41:0] s4_pcr_reg;
    logic [23:0]        s4_yy_reg;
    logic [7:0]         s4_y_reg;
    logic signed [7:0]  s4_db_reg;
    logic signed [7:0]  s4_dr_reg;
    yrmc_pkg::model_t   s4_model_reg;

    assign dby = $signed({1'b0, s3_b_reg}) - $signed({1'b0, s3_yy_reg});
    assign dry = $signed({1'b0, s3_r_reg}) - $signed({1'b0, s3_yy_reg});
    assign s4_pcb_next = $signed({{17{dby[24]}}, dby})
                         * $signed({25'd0, yrmc_pkg::K_INV_CB});
    assign s4_pcr_next = $signed({{17{dry[24]}}, dry})
                         * $signed({25'd0, yrmc_pkg::K_INV_CR});

    always_ff @(posedge clk)
    begin
        if (stage_en[4])
        begin
            s4_pcb_reg   <= s4_pcb_next;
            s4_pcr_reg   <= s4_pcr_next;
            s4_yy_reg    <= s3_yy_reg;
            s4_y_reg     <= s3_y_reg;
            s4_db_reg    <= s3_db_reg;
            s4_dr_reg    <= s3_dr_reg;
            s4_model_reg <= s3_model_reg;
        end
    end

    // Stage 5: pick the BT.709 or pass-through luma and chroma deltas.
    logic               to709;
    logic signed [41:0] pcb_rnd;
    logic signed [41:0] pcr_rnd;
    logic [23:0]        s5_y_next;
    logic signed [25:0] s5_dcb_next;
    logic signed [25:0] s5_dcr_next;
    logic [23:0]        s5_y_reg;
    logic signed [25:0] s5_dcb_reg;
    logic signed [25:0] s5_dcr_reg;
    logic               s5_lim_reg;

    assign to709   = s4_model_reg[yrmc_pkg::MODEL_709_BIT];
    assign pcb_rnd = s4_pcb_reg + 42'sd32768;
    assign pcr_rnd = s4_pcr_reg + 42'sd32768;

    always_comb
    begin
        if (to709)
        begin
            s5_y_next   = s4_yy_reg;
            s5_dcb_next = $signed(pcb_rnd[41:16]);
            s5_dcr_next = $signed(pcr_rnd[41:16]);
        end
        else
        begin
            s5_y_next   = {s4_y_reg, 16'h0000};
            s5_dcb_next = $signed({{2{s4_db_reg[7]}}, s4_db_reg, 16'h0000});
            s5_dcr_next = $signed({{2{s4_dr_reg[7]}}, s4_dr_reg, 16'h0000});
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[5])
        begin
            s5_y_reg   <= s5_y_next;
            s5_dcb_reg <= s5_dcb_next;
            s5_dcr_reg <= s5_dcr_next;
            s5_lim_reg <= s4_model_reg[yrmc_pkg::MODEL_LIM_BIT];
        end
    end

    // Stage 6: limited-range scale products.
    logic [40:0]        s6_ly_next;
    logic signed [42:0] s6_lcb_next;
    logic signed [42:0] s6_lcr_next;
    logic [40:0]        s6_ly_reg;
    logic signed [42:0] s6_lcb_reg;
    logic signed [42:0] s6_lcr_reg;
    logic [23:0]        s6_y_reg;
    logic signed [25:0] s6_dcb_reg;
    logic signed [25:0] s6_dcr_reg;
    logic               s6_lim_reg;

    assign s6_ly_next  = {17'd0, s5_y_reg} * {24'd0, yrmc_pkg::K_LIM_Y};
    assign s6_lcb_next = $signed({{17{s5_dcb_reg[25]}}, s5_dcb_reg})
                         * $signed({26'd0, yrmc_pkg::K_LIM_C});
    assign s6_lcr_next = $signed({{17{s5_dcr_reg[25]}}, s5_dcr_reg})
                         * $signed({26'd0, yrmc_pkg::K_LIM_C});

    always_ff @(posedge clk)
    begin
        if (stage_en[6])
        begin
            s6_ly_reg  <= s6_ly_next;
            s6_lcb_reg <= s6_lcb_next;
            s6_lcr_reg <= s6_lcr_next;
            s6_y_reg   <= s5_y_reg;
            s6_dcb_reg <= s5_dcb_reg;
            s6_dcr_reg <= s5_dcr_reg;
            s6_lim_reg <= s5_lim_reg;
        end
    end

    // Stage 7: rounding of the scaled values and the code offsets.
    logic [40:0]        ly_rnd;
    logic signed [42:0] lcb_rnd;
    logic signed [42:0] lcr_rnd;
    logic signed [26:0] dcb_fin;
    logic signed [26:0] dcr_fin;
    logic [24:0]        s7_y_next;
    logic signed [27:0] s7_cb_next;
    logic signed [27:0] s7_cr_next;
    logic [24:0]        s7_y_reg;
    logic signed [27:0] s7_cb_reg;
    logic signed [27:0] s7_cr_reg;

    assign ly_rnd  = s6_ly_reg + 41'd32768;
    assign lcb_rnd = s6_lcb_reg + 43'sd32768;
    assign lcr_rnd = s6_lcr_reg + 43'sd32768;

    always_comb
    begin
        if (s6_lim_reg)
        begin
            s7_y_next = LIM_OFS + ly_rnd[40:16];
            dcb_fin   = $signed(lcb_rnd[42:16]);
            dcr_fin   = $signed(lcr_rnd[42:16]);
        end
        else
        begin
            s7_y_next = {1'b0, s6_y_reg};
            dcb_fin   = $signed({s6_dcb_reg[25], s6_dcb_reg});
            dcr_fin   = $signed({s6_dcr_reg[25], s6_dcr_reg});
        end
        s7_cb_next = $signed(MID) + $signed({dcb_fin[26], dcb_fin});
        s7_cr_next = $signed(MID) + $signed({dcr_fin[26], dcr_fin});
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[7])
        begin
            s7_y_reg  <= s7_y_next;
            s7_cb_reg <= s7_cb_next;
            s7_cr_reg <= s7_cr_next;
        end
    end

    // Stage 8: output register with rounding and saturation.
    logic [15:0] s8_y_reg;
    logic [15:0] s8_cb_reg;
    logic [15:0] s8_cr_reg;

    always_ff @(posedge clk)
    begin
        if (stage_en[8])
        begin
            s8_y_reg  <= to_output($signed({3'b000, s7_y_reg}));
            s8_cb_reg <= to_output(s7_cb_reg);
            s8_cr_reg <= to_output(s7_cr_reg);
        end
    end

    assign luma_q      = s8_y_reg;
    assign blue_diff_q = s8_cb_reg;
    assign red_diff_q  = s8_cr_reg;

endmodule

>>> tb/sv/testbench.sv
// ---------------------------------------------------------------------------
// YCbCr range/matrix converter: testbench
// Sends full-range BT.601 pixels through the converter under all four output
// models, with random gaps on the input and random stalls on the result
// channel. Every result transaction is checked field by field against a
// fixed-point predictor that is kept inside this file.
// ---------------------------------------------------------------------------
module testbench;

    // Output model codes.
    localparam yrmc_pkg::model_t MODEL_FULL_601 = 2'd0;
    localparam yrmc_pkg::model_t MODEL_LIM_601  = 2'd1;
    localparam yrmc_pkg::model_t MODEL_FULL_709 = 2'd2;
    localparam yrmc_pkg::model_t MODEL_LIM_709  = 2'd3;

    // Fixed-point layout of the predictor.
    localparam int     FRAC       = yrmc_pkg::Q_BITS;
    localparam int     OUT_FRAC   = yrmc_pkg::OUT_FRAC_BITS_DEF;
    localparam longint CODE_MID   = longint'(128) << FRAC;
    localparam longint CODE_TOP   = longint'(255) << FRAC;
    localparam longint LIM_FLOOR  = longint'(16) << FRAC;
    localparam longint MAX_Q88    = 65535;

    // Coefficients as signed 64-bit values so products stay signed.
    localparam longint COEF_RED_CR   = longint'(yrmc_pkg::K_R_CR);
    localparam longint COEF_GRN_CB   = longint'(yrmc_pkg::K_G_CB);
    localparam longint COEF_GRN_CR   = longint'(yrmc_pkg::K_G_CR);
    localparam longint COEF_BLU_CB   = longint'(yrmc_pkg::K_B_CB);
    localparam longint WEIGHT_RED    = longint'(yrmc_pkg::K_WR);
    localparam longint WEIGHT_GRN    = longint'(yrmc_pkg::K_WG);
    localparam longint WEIGHT_BLU    = longint'(yrmc_pkg::K_WB);
    localparam longint SCALE_CB      = longint'(yrmc_pkg::K_INV_CB);
    localparam longint SCALE_CR      = longint'(yrmc_pkg::K_INV_CR);
    localparam longint SQUEEZE_LUMA  = longint'(yrmc_pkg::K_LIM_Y);
    localparam longint SQUEEZE_CHROMA = longint'(yrmc_pkg::K_LIM_C);

    // Run shape.
    localparam int NUM_PHASES      = 8;
    localparam int PIXELS_PER_PHASE = 180;
    localparam int NUM_DIRECTED    = 19;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int TAIL_CYCLES     = 30;
    localparam int MAX_REPORTS     = 10;

    typedef struct packed {
        logic [15:0] luma;
        logic [15:0] blue;
        logic [15:0] red;
    } pixel_q88_t;

    typedef struct {
        yrmc_pkg::model_t model;
        logic [7:0]       luma;
        logic [7:0]       blue;
        logic [7:0]       red;
        bit               typed;
        logic [15:0]      want_luma;
        logic [15:0]      want_blue;
        logic [15:0]      want_red;
    } pixel_case_t;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_wr_en;
    yrmc_pkg::model_t cfg_wr_data;

    yrmc_in_if  pixel_if ();
    yrmc_out_if result_if ();

    yrmc_pkg::model_t active_model;
    pixel_q88_t       converted_q[$];
    int               fail_count;
    int               quiet_cycles;

    // Directed pixels: extremes, alternating bit patterns and clamp corners.
    pixel_case_t directed_cases [NUM_DIRECTED] = '{
        '{MODEL_FULL_601, 8'd0,   8'd0,   8'd0,   1'b1, 16'd0,     16'd0,     16'd0},
        '{MODEL_FULL_601, 8'd255, 8'd255, 8'd255, 1'b1, 16'd65280, 16'd65280, 16'd65280},
        '{MODEL_FULL_601, 8'h55,  8'hAA,  8'h55,  1'b1, 16'h5500,  16'hAA00,  16'h5500},
        '{MODEL_FULL_601, 8'hAA,  8'h55,  8'hAA,  1'b1, 16'hAA00,  16'h5500,  16'hAA00},
        '{MODEL_LIM_601,  8'd0,   8'd128, 8'd128, 1'b1, 16'd4096,  16'd32768, 16'd32768},
        '{MODEL_LIM_601,  8'd255, 8'd0,   8'd255, 1'b0, 16'd0,     16'd0,     16'd0},
        '{MODEL_LIM_601,  8'd128, 8'd255, 8'd0,   1'b0, 16'd0,     16'd0,     16'd0},
        '{MODEL_FULL_709, 8'd128, 8'd128, 8'd128, 1'b1, 16'd32768, 16'd32768, 16'd32768},
        '{MODEL_FULL_709, 8'd0,   8'd128, 8'd128, 1'b1, 16'd0,     16'd32768, 16'd32768},
        '{MODEL_FULL_709, 8'd255, 8'd128, 8'd128, 1'b1, 16'd65280, 16'd32768, 16'd32768},
        '{MODEL_FULL_709, 8'd0,   8'd255, 8'd0,   1'b0, 16'd0,     16'd0,     16'd0},
        '{MODEL_FULL_709, 8'd255, 8'd0,   8'd255, 1'b0, 16'd0,     16'd0,     16'd0},
        '{MODEL_FULL_709, 8'd0,   8'd0,   8'd255, 1'b0, 16'd0,     16'd0,     16'd0},
        '{MODEL_FULL_709, 8'd255, 8'd255, 8'd0,   1'b0, 16'd0,     16'd0,     16'd0},
        '{MODEL_LIM_709,  8'd0,   8'd128, 8'd128, 1'b1, 16'd4096,  16'd32768, 16'd32768},
        '{MODEL_LIM_709,  8'd255, 8'd255, 8'd255, 1'b0, 16'd0,     16'd0,     16'd0},
        '{MODEL_LIM_709,  8'd0,   8'd255, 8'd0,   1'b0, 16'd0,     16'd0,     16'd0},
        '{MODEL_LIM_709,  8'd255, 8'd0,   8'd255, 1'b0, 16'd0,     16'd0,     16'd0},
        '{MODEL_FULL_601, 8'd128, 8'd128, 8'd128, 1'b1, 16'd32768, 16'd32768, 16'd32768}
    };

    ycbcr_range_matrix_convert_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .pixel       (pixel_if),
        .result      (result_if)
    );

    always #5 clk = ~clk;

    // Round to nearest with ties toward plus infinity, then drop s bits.
    function automatic longint round_shift(longint x, int s);
        if (s == 0)
            return x;
        return (x + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint clamp_level(longint x);
        if (x < 0)
            return 0;
        return (x > CODE_TOP) ? CODE_TOP : x;
    endfunction

    function automatic logic [15:0] to_q88(longint v);
        longint r;
        if (v < 0)
            v = 0;
        r = round_shift(v, FRAC - OUT_FRAC);
        if (r > MAX_Q88)
            r = MAX_Q88;
        return r[15:0];
    endfunction

    // Expected output pixel for one input pixel under the given model.
    function automatic pixel_q88_t convert_pixel(yrmc_pkg::model_t m, logic [7:0] y8,
                                                 logic [7:0] cb8, logic [7:0] cr8);
        longint     y;
        longint     cb;
        longint     cr;
        longint     db;
        longint     dr;
        longint     red;
        longint     grn;
        longint     blu;
        longint     y709;
        pixel_q88_t res;
        y  = longint'(y8) << FRAC;
        cb = longint'(cb8) << FRAC;
        cr = longint'(cr8) << FRAC;
        // Through clamped RGB and back with BT.709 weights.
        if (m[yrmc_pkg::MODEL_709_BIT])
        begin
            db   = longint'(cb8) - 128;
            dr   = longint'(cr8) - 128;
            red  = clamp_level(y + COEF_RED_CR * dr);
            grn  = clamp_level(y - COEF_GRN_CB * db - COEF_GRN_CR * dr);
            blu  = clamp_level(y + COEF_BLU_CB * db);
            y709 = round_shift(WEIGHT_RED * red + WEIGHT_GRN * grn + WEIGHT_BLU * blu, FRAC);
            y    = y709;
            cb   = CODE_MID + round_shift((blu - y709) * SCALE_CB, FRAC);
            cr   = CODE_MID + round_shift((red - y709) * SCALE_CR, FRAC);
        end
        // Limited-range squeeze.
        if (m[yrmc_pkg::MODEL_LIM_BIT])
        begin
            y  = LIM_FLOOR + round_shift(y * SQUEEZE_LUMA, FRAC);
            cb = CODE_MID + round_shift((cb - CODE_MID) * SQUEEZE_CHROMA, FRAC);
            cr = CODE_MID + round_shift((cr - CODE_MID) * SQUEEZE_CHROMA, FRAC);
        end
        res.luma = to_q88(y);
        res.blue = to_q88(cb);
        res.red  = to_q88(cr);
        return res;
    endfunction

    // Idle length: mostly none or short, now and then long.
    function automatic int unsigned idle_len();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return 0;
        if (pick < 85)
            return $urandom_range(1, 3);
        if (pick < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    // Random code, with a share of corner values.
    function automatic logic [7:0] rand_code();
        if ($urandom_range(0, 9) != 0)
            return 8'($urandom_range(0, 255));
        unique case ($urandom_range(0, 5))
            0:       return 8'd0;
            1:       return 8'd255;
            2:       return 8'd128;
            3:       return 8'd127;
            4:       return 8'd1;
            default: return 8'd254;
        endcase
    endfunction

    // Present one pixel and wait for its transaction, then log what it must give.
    task automatic send_pixel(logic [7:0] y, logic [7:0] cb, logic [7:0] cr,
                              bit typed, pixel_q88_t typed_res);
        pixel_q88_t expected;
        pixel_if.valid        <= 1'b1;
        pixel_if.luma_in      <= y;
        pixel_if.blue_diff_in <= cb;
        pixel_if.red_diff_in  <= cr;
        do
            @(posedge clk);
        while (pixel_if.ready !== 1'b1);
        expected    = typed ? typed_res : convert_pixel(active_model, y, cb, cr);
        converted_q = {converted_q, expected};
    endtask

    task automatic hold_off(int unsigned cycles);
        if (cycles != 0)
        begin
            pixel_if.valid <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    // Let the pipeline empty, then change the output model.
    task automatic write_model(yrmc_pkg::model_t m);
        pixel_if.valid <= 1'b0;
        while (converted_q.size() != 0)
            @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= m;
        @(posedge clk);
        cfg_wr_en    <= 1'b0;
        active_model = m;
    endtask

    task automatic compare_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want)
        begin
            if (fail_count < MAX_REPORTS)
                $display("mismatch on %s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // Stimulus: reset, directed table, then random phases.
    initial
    begin
        pixel_q88_t       typed_res;
        bit               quiet_phase;
        yrmc_pkg::model_t phase_model;
        rst_n                 = 1'b0;
        cfg_wr_en             = 1'b0;
        cfg_wr_data           = MODEL_FULL_601;
        pixel_if.valid        = 1'b0;
        pixel_if.luma_in      = 8'd0;
        pixel_if.blue_diff_in = 8'd0;
        pixel_if.red_diff_in  = 8'd0;
        active_model          = MODEL_FULL_601;
        fail_count            = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The first rows run on the model left by reset.
        foreach (directed_cases[i])
        begin
            if (directed_cases[i].model != active_model)
                write_model(directed_cases[i].model);
            typed_res = '{directed_cases[i].want_luma, directed_cases[i].want_blue,
                          directed_cases[i].want_red};
            send_pixel(directed_cases[i].luma, directed_cases[i].blue,
                       directed_cases[i].red, directed_cases[i].typed, typed_res);
            hold_off(idle_len());
        end

        // Random phases, each on one model; the first two hit both extremes.
        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            if (phase == 0)
                phase_model = MODEL_LIM_709;
            else if (phase == 1)
                phase_model = MODEL_FULL_601;
            else
                phase_model = yrmc_pkg::model_t'($urandom_range(0, 3));
            write_model(phase_model);
            quiet_phase = (phase % 3 == 1);
            for (int k = 0; k < PIXELS_PER_PHASE; k++)
            begin
                send_pixel(rand_code(), rand_code(), rand_code(), 1'b0, '0);
                if (!quiet_phase)
                    hold_off(idle_len());
            end
        end

        pixel_if.valid <= 1'b0;
        while (converted_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

    // Result side: ready in random bursts, with long open stretches now and then.
    initial
    begin
        int unsigned open_len;
        int unsigned stall_len;
        result_if.ready = 1'b0;
        @(posedge clk);
        forever
        begin
            open_len = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                   : $urandom_range(1, 20);
            result_if.ready <= 1'b1;
            repeat (open_len) @(posedge clk);
            stall_len = idle_len();
            if (stall_len != 0)
            begin
                result_if.ready <= 1'b0;
                repeat (stall_len) @(posedge clk);
            end
        end
    end

    // Check each result transaction against the oldest expected pixel.
    always @(posedge clk)
    begin
        pixel_q88_t want;
        if (rst_n === 1'b1 && result_if.valid === 1'b1 && result_if.ready === 1'b1)
        begin
            if (converted_q.size() == 0)
            begin
                if (fail_count < MAX_REPORTS)
                    $display("unexpected result: %0d %0d %0d", result_if.luma_out,
                             result_if.blue_diff_out, result_if.red_diff_out);
                fail_count++;
            end
            else
            begin
                want = converted_q.pop_front();
                compare_field("luma_out", want.luma, result_if.luma_out);
                compare_field("blue_diff_out", want.blue, result_if.blue_diff_out);
                compare_field("red_diff_out", want.red, result_if.red_diff_out);
            end
        end
    end

    // Watchdog on cycles without any transaction.
    always @(posedge clk)
    begin
        if ((pixel_if.valid === 1'b1 && pixel_if.ready === 1'b1) ||
            (result_if.valid === 1'b1 && result_if.ready === 1'b1))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("testbench: done, errors");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial quiet_cycles = 0;

endmodule
